/* hdl/e2q_pkg.sv */
// ============================================================================
// e2q_pkg: shared constants and types for the Euler-to-quaternion converter
// Holds the CORDIC angle table, gain and output format constants.
// ============================================================================
package e2q_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int ANGLE_LIMIT   = 25736;
    localparam int CW            = 34;   // CORDIC datapath width, Q.30 plus headroom
    localparam int OSH           = 30 - OUT_FRAC_BITS;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    typedef logic signed [CW-1:0] t_q30;

    function automatic t_q30 atan_q30(input int idx);
        t_q30 v;
        unique case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            default: v = 34'sd128;
        endcase
        return v;
    endfunction

    // Q.30 product with round half up (add 2^29, floor shift by 30).
    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [2*CW-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return t_q30'(p >>> 30);
    endfunction

endpackage

/* hdl/e2q_cordic.sv */
// ============================================================================
// e2q_cordic: pipelined CORDIC lane
// One rotation stage per register; gives sine and cosine of half an angle.
// ============================================================================
module e2q_cordic
    import e2q_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output t_q30               o_sin,
    output t_q30               o_cos
);

    t_q30 r_x [0:CORDIC_STEPS];
    t_q30 r_y [0:CORDIC_STEPS];
    t_q30 r_z [0:CORDIC_STEPS];
    logic signed [15:0] w_clamped;

    always_comb begin
        if (i_angle > 16'sd25736) begin
            w_clamped = 16'sd25736;
        end else if (i_angle < -16'sd25736) begin
            w_clamped = -16'sd25736;
        end else begin
            w_clamped = i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= t_q30'(w_clamped) <<< 16;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(g);
                end
            end
        end
    end

    assign o_sin = r_y[CORDIC_STEPS];
    assign o_cos = r_x[CORDIC_STEPS];

endmodule

/* hdl/e2q_merge.sv */
// ============================================================================
// e2q_merge: product and combine stage
// Forms pair products, triple products, sums and saturated outputs.
// ============================================================================
module e2q_merge
    import e2q_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  t_q30               i_sx,
    input  t_q30               i_cx,
    input  t_q30               i_sy,
    input  t_q30               i_cy,
    input  t_q30               i_sz,
    input  t_q30               i_cz,
    output logic signed [15:0] o_w,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y,
    output logic signed [15:0] o_z
);

    t_q30 r_cc, r_ss, r_sc, r_cs, r_sz, r_cz;
    t_q30 r_p [0:7];
    t_q30 r_s [0:3];

    function automatic logic signed [15:0] to_out(input t_q30 v);
        t_q30 r;
        r = (v + (t_q30'(1) <<< (OSH - 1))) >>> OSH;
        if (r > t_q30'(1 <<< OUT_FRAC_BITS)) begin
            r = t_q30'(1 <<< OUT_FRAC_BITS);
        end else if (r < -t_q30'(1 <<< OUT_FRAC_BITS)) begin
            r = -t_q30'(1 <<< OUT_FRAC_BITS);
        end
        return r[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc <= mul_q30(i_cx, i_cy);
            r_ss <= mul_q30(i_sx, i_sy);
            r_sc <= mul_q30(i_sx, i_cy);
            r_cs <= mul_q30(i_cx, i_sy);
            r_sz <= i_sz;
            r_cz <= i_cz;
            r_p[0] <= mul_q30(r_cc, r_cz);
            r_p[1] <= mul_q30(r_ss, r_sz);
            r_p[2] <= mul_q30(r_sc, r_cz);
            r_p[3] <= mul_q30(r_cs, r_sz);
            r_p[4] <= mul_q30(r_cs, r_cz);
            r_p[5] <= mul_q30(r_sc, r_sz);
            r_p[6] <= mul_q30(r_cc, r_sz);
            r_p[7] <= mul_q30(r_ss, r_cz);
            r_s[0] <= r_p[0] + r_p[1];
            r_s[1] <= r_p[2] - r_p[3];
            r_s[2] <= r_p[4] + r_p[5];
            r_s[3] <= r_p[6] - r_p[7];
            o_w <= to_out(r_s[0]);
            o_x <= to_out(r_s[1]);
            o_y <= to_out(r_s[2]);
            o_z <= to_out(r_s[3]);
        end
    end

endmodule

/* hdl/euler_to_quaternion.sv */
// ============================================================================
// euler_to_quaternion: Euler angles to rotation quaternion
// Three CORDIC lanes feed a product and combine stage.
// ============================================================================
// Usage: present roll, pitch and yaw (signed Q3.13 radians) with i_valid.
// A transaction is taken at a clock edge with i_valid high and o_stall low.
// Results appear on o_quat_* with o_valid and are taken when i_stall is low.
// The pipeline has one clamp/load stage, one stage per CORDIC rotation,
// then pair product, triple product, sum and output rounding stages.
// Throughput is one transaction per cycle while o_stall is low.
// The pipeline advances as a whole; it freezes only when the output
// register holds a result and the receiver stalls, and o_stall then rises.
// Synchronous active-low reset clears the valid pipeline; data is not reset.
// ============================================================================
module euler_to_quaternion
    import e2q_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);

    localparam int DEPTH = CORDIC_STEPS + 5;

    logic [DEPTH-1:0] r_vld;
    logic             w_en;
    t_q30 w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    assign w_en    = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    e2q_cordic u_roll  (.i_clk, .i_en(w_en), .i_angle(i_roll_angle),
                        .o_sin(w_sx), .o_cos(w_cx));
    e2q_cordic u_pitch (.i_clk, .i_en(w_en), .i_angle(i_pitch_angle),
                        .o_sin(w_sy), .o_cos(w_cy));
    e2q_cordic u_yaw   (.i_clk, .i_en(w_en), .i_angle(i_yaw_angle),
                        .o_sin(w_sz), .o_cos(w_cz));

    e2q_merge u_merge (
        .i_clk, .i_en(w_en),
        .i_sx(w_sx), .i_cx(w_cx), .i_sy(w_sy), .i_cy(w_cy),
        .i_sz(w_sz), .i_cz(w_cz),
        .o_w(o_quat_w), .o_x(o_quat_x), .o_y(o_quat_y), .o_z(o_quat_z)
    );

endmodule

/* hdl/e2q_checker.sv */
// ============================================================================
// e2q_checker: port-level checks for the converter
// Watches handshakes and the w and x output ranges on the top-level ports.
// ============================================================================
module e2q_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_quat_w,
    input logic signed [15:0] o_quat_x
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_quat_w))
        else $error("stalled result changed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall without a blocked result");

    a_range_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quat_w <= 16'sd16384 && o_quat_w >= -16'sd16384)
        else $error("w out of range");

    a_range_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quat_x <= 16'sd16384 && o_quat_x >= -16'sd16384)
        else $error("x out of range");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
    .o_quat_w, .o_quat_x
);

/* bench/e2q_checker.sv */
// ----------------------------------------------------------------------------
// e2q_scoreboard: scoreboard for the Euler-to-quaternion converter
// Watches both channels, predicts each quaternion from the accepted angles
// and compares every output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module e2q_scoreboard
    import e2q_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_roll,
    input  logic signed [15:0] i_pitch,
    input  logic signed [15:0] i_yaw,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_w,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_quat;

    localparam longint HALF_GAIN = 64'sd652032874;
    localparam longint ARCTAN [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    t_quat expected_quats[$];
    int    fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_quats.size();

    function automatic longint limit_angle(logic signed [15:0] a);
        longint v;
        v = a;
        if (v > ANGLE_LIMIT) v = ANGLE_LIMIT;
        if (v < -ANGLE_LIMIT) v = -ANGLE_LIMIT;
        return v;
    endfunction

    // Rotation-mode CORDIC on the half angle (input Q.13 shifted to Q.30 halves it).
    function automatic void half_sin_cos(input longint ang, output longint s,
                                         output longint c);
        longint xr, yr, zr, dx, dy;
        xr = HALF_GAIN;
        yr = 0;
        zr = ang * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = xr >>> i;
            dy = yr >>> i;
            if (zr >= 0) begin
                xr -= dy;
                yr += dx;
                zr -= ARCTAN[i];
            end else begin
                xr += dy;
                yr -= dx;
                zr += ARCTAN[i];
            end
        end
        s = yr;
        c = xr;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [15:0] to_quat_field(longint v);
        longint lim;
        int     sh;
        lim = 64'sd1 <<< OUT_FRAC_BITS;
        sh  = 30 - OUT_FRAC_BITS;
        if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[15:0];
    endfunction

    function automatic t_quat quat_from_euler(logic signed [15:0] r,
                                              logic signed [15:0] p,
                                              logic signed [15:0] yw);
        longint sx, cx, sy, cy, sz, cz, cc, ss, sc, cs;
        t_quat  q;
        half_sin_cos(limit_angle(r), sx, cx);
        half_sin_cos(limit_angle(p), sy, cy);
        half_sin_cos(limit_angle(yw), sz, cz);
        cc = qmul(cx, cy);
        ss = qmul(sx, sy);
        sc = qmul(sx, cy);
        cs = qmul(cx, sy);
        q.w = to_quat_field(qmul(cc, cz) + qmul(ss, sz));
        q.x = to_quat_field(qmul(sc, cz) - qmul(cs, sz));
        q.y = to_quat_field(qmul(cs, cz) + qmul(sc, sz));
        q.z = to_quat_field(qmul(cc, sz) - qmul(ss, cz));
        return q;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_quat want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_quats.size() == 0) begin
                    $display("unexpected output transaction at %0t", $realtime);
                    fails++;
                end else begin
                    want = expected_quats.pop_front();
                    if (i_w !== want.w) report_mismatch("w", i_w, want.w);
                    if (i_x !== want.x) report_mismatch("x", i_x, want.x);
                    if (i_y !== want.y) report_mismatch("y", i_y, want.y);
                    if (i_z !== want.z) report_mismatch("z", i_z, want.z);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_quats.push_back(quat_from_euler(i_roll, i_pitch, i_yaw));
        end
    end

endmodule

/* bench/euler_to_quaternion_tb.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb: top-level bench for the Euler-to-quaternion converter
// Drives directed and random angle triples in bursts against a stalling
// receiver; the checker module predicts and compares every quaternion.
// ----------------------------------------------------------------------------
module euler_to_quaternion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic signed [15:0] roll = '0, pitch = '0, yaw = '0;
    logic               o_stall, o_valid;
    logic signed [15:0] qw, qx, qy, qz;
    int                 fail_count, pending;
    logic               hold_req = 1'b0;
    int                 idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    euler_to_quaternion u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_roll_angle(roll), .i_pitch_angle(pitch), .i_yaw_angle(yaw),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_quat_w(qw), .o_quat_x(qx), .o_quat_y(qy), .o_quat_z(qz)
    );

    e2q_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_roll(roll), .i_pitch(pitch), .i_yaw(yaw),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_w(qw), .i_x(qx), .i_y(qy), .i_z(qz),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stall density is redrawn at random moments; a hold request
    // forces a long stretch of stall so the pipeline backs up.
    always @(posedge i_clk) begin
        int hold_left;
        int density;
        int phase;
        if (hold_req && hold_left == 0 && phase >= 0) begin
            hold_left = 300;
            phase = -1;
        end
        if (!hold_req) phase = 0;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 63) == 0) density = $urandom_range(0, 3) * 25;
            i_stall <= ($urandom_range(0, 99) < density);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic signed [15:0] random_angle();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 16'sd25736;
        if (pick == 1) return -16'sd25736;
        if (pick < 4) return 16'($urandom_range(0, 65535));
        return 16'(int'($urandom_range(0, 51472)) - 25736);
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic offer_angles(logic signed [15:0] r, logic signed [15:0] p,
                                logic signed [15:0] yw);
        i_valid <= 1'b1;
        roll    <= r;
        pitch   <= p;
        yaw     <= yw;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic pause_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        logic signed [15:0] corners [8];
        int sent;
        int burst;
        corners = '{16'sd0, 16'sd25736, -16'sd25736,
            16'sd32767, -16'sd32768, 16'sd12868, -16'sd12868, 16'sd1};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner angles: zero, plus and minus pi, saturating inputs, quarter turns.
        for (int i = 0; i < 8; i++) offer_angles(corners[i], corners[i], corners[i]);
        for (int i = 0; i < 8; i++) offer_angles(corners[i], corners[7 - i], corners[(i + 3) % 8]);
        offer_angles(16'sd25736, 16'sd0, 16'sd0);
        offer_angles(16'sd0, 16'sd25736, 16'sd0);
        offer_angles(16'sd0, 16'sd0, 16'sd25736);
        offer_angles(-16'sd32768, 16'sd32767, -16'sd1);
        pause_sender(1);
        wait (pending == 0);

        sent = 0;
        while (sent < 1750) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                offer_angles(random_angle(), random_angle(), random_angle());
                sent++;
            end
            if (sent > 400 && sent < 450 && !hold_req) hold_req <= 1'b1;
            if (sent > 900 && hold_req) begin
                hold_req <= 1'b0;
                pause_sender(1);
                wait (pending == 0);
            end
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        end
        pause_sender(1);
        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* euler_to_quaternion.f */
hdl/e2q_pkg.sv
hdl/e2q_cordic.sv
hdl/e2q_merge.sv
hdl/euler_to_quaternion.sv
hdl/e2q_checker.sv
bench/e2q_checker.sv
bench/euler_to_quaternion_tb.sv
